// File: rtl/core/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray / box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int T_W         = 32;
   localparam int T_FRAC_DEF  = 16;
   localparam int NUM_REGS    = 6;
   localparam int REG_IDX_W   = 3;

   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_X = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_Y = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_Z = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [T_W-1:0]     t_type;

   localparam t_type T_MAX = {1'b0, {(T_W-1){1'b1}}};
   localparam t_type T_MIN = {1'b1, {(T_W-1){1'b0}}};

   typedef struct packed {
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } req_type;

   typedef struct packed {
      logic  hit;
      t_type t_enter;
      t_type t_exit;
   } rsp_type;

   // per-axis side information for a zero direction component
   typedef struct packed {
      logic zero_dir;
      logic in_slab;
   } axis_flag_type;

endpackage

// File: rtl/core/rbst_div_lane.sv
// ----------------------------------------------------------------------------
// rbst_div_lane
// Pipelined restoring divider, one quotient bit per stage, with a signed
// Q16.16 (default T_FRAC_BITS) saturating output register.
// ----------------------------------------------------------------------------
module rbst_div_lane #(
   parameter int T_FRAC_BITS = rbst_pkg::T_FRAC_DEF
) (
   input  logic                       clock,
   input  logic [rbst_pkg::DIFF_W-1:0] num_mag,
   input  logic                       num_neg,
   input  logic [rbst_pkg::DIFF_W-1:0] den_mag,
   input  logic                       den_neg,
   output rbst_pkg::t_type            quot
);
   import rbst_pkg::*;

   localparam int QW = DIFF_W + T_FRAC_BITS;
   localparam int EW = (QW > T_W + 1) ? QW : T_W + 1;
   localparam logic [EW-1:0] POS_LIM = EW'({1'b0, {(T_W-1){1'b1}}});
   localparam logic [EW-1:0] NEG_LIM = EW'({1'b1, {(T_W-1){1'b0}}});

   logic [DIFF_W-1:0] rem_ff [QW];
   logic [DIFF_W-1:0] rem_in [QW];
   logic [QW-1:0]     quo_ff [QW];
   logic [QW-1:0]     quo_in [QW];
   logic              neg_ff [QW];
   logic              neg_in [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DIFF_W-1:0] rem_src;
      logic [QW-1:0]     quo_src;
      logic              neg_src;
      logic [DIFF_W:0]   trial;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign quo_src = {num_mag, {T_FRAC_BITS{1'b0}}};
         assign neg_src = num_neg ^ den_neg;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign neg_src = neg_ff[s-1];
      end

      assign trial = {rem_src, quo_src[QW-1]};

      always_comb begin
         neg_in[s] = neg_src;
         if (trial >= {1'b0, den_mag}) begin
            rem_in[s] = DIFF_W'(trial - {1'b0, den_mag});
            quo_in[s] = {quo_src[QW-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[DIFF_W-1:0];
            quo_in[s] = {quo_src[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         neg_ff[s] <= neg_in[s];
      end
   end

   logic [EW-1:0] q_ext;
   logic [EW-1:0] q_neg;
   t_type         quot_ff;
   t_type         quot_in;

   assign q_ext = EW'(quo_ff[QW-1]);
   assign q_neg = EW'(0) - q_ext;

   always_comb begin
      if (neg_ff[QW-1]) begin
         quot_in = (q_ext > NEG_LIM) ? T_MIN : t_type'(q_neg[T_W-1:0]);
      end else begin
         quot_in = (q_ext > POS_LIM) ? T_MAX : t_type'(q_ext[T_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// File: rtl/core/rbst_merge.sv
// ----------------------------------------------------------------------------
// rbst_merge
// Orders each axis pair, handles zero direction, then takes the largest
// entry, the smallest exit and the hit flag. Two register stages.
// ----------------------------------------------------------------------------
module rbst_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid,
   input  rbst_pkg::t_type         t_lo   [3],
   input  rbst_pkg::t_type         t_hi   [3],
   input  rbst_pkg::axis_flag_type flag   [3],
   output logic                    rsp_valid,
   output rbst_pkg::rsp_type       rsp_data
);
   import rbst_pkg::*;

   logic  valid_a_ff;
   t_type en_ff [3];
   t_type en_in [3];
   t_type ex_ff [3];
   t_type ex_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (flag[k].zero_dir) begin
            en_in[k] = flag[k].in_slab ? T_MIN : T_MAX;
            ex_in[k] = flag[k].in_slab ? T_MAX : T_MIN;
         end else if (t_lo[k] > t_hi[k]) begin
            en_in[k] = t_hi[k];
            ex_in[k] = t_lo[k];
         end else begin
            en_in[k] = t_lo[k];
            ex_in[k] = t_hi[k];
         end
      end
   end

   t_type   enter;
   t_type   exit_t;
   logic    valid_b_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      enter  = en_ff[0];
      exit_t = ex_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (en_ff[k] > enter) begin
            enter = en_ff[k];
         end
         if (ex_ff[k] < exit_t) begin
            exit_t = ex_ff[k];
         end
      end
      rsp_in.hit     = (enter <= exit_t);
      rsp_in.t_enter = enter;
      rsp_in.t_exit  = exit_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid;
         valid_b_ff <= valid_a_ff;
      end
      for (int k = 0; k < 3; k++) begin
         en_ff[k] <= en_in[k];
         ex_ff[k] <= ex_in[k];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_b_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test, one box per clock.
// ----------------------------------------------------------------------------
// A box is taken in every cycle in which start is high; busy is always low.
// Each box gives one result, strobed by rsp_valid for one cycle, in the
// order taken. The receiver cannot stall: each result must be taken in its
// strobe cycle. A box passes a difference stage, the six pipelined
// restoring dividers, one quotient bit per stage, a saturation stage and
// two merge stages. Ray origin and target registers may only be written
// while no box is in flight.
module ray_box_slab_test #(
   parameter int T_FRAC_BITS = rbst_pkg::T_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rbst_pkg::req_type               req_box,
   output logic                            rsp_valid,
   output rbst_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [rbst_pkg::REG_IDX_W-1:0]  csr_index,
   input  rbst_pkg::coord_type             csr_data
);
   import rbst_pkg::*;

   localparam int QW       = DIFF_W + T_FRAC_BITS;
   localparam int LANE_LAT = QW + 1;
   localparam int LAT      = LANE_LAT + 3;

   coord_type cfg_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: cfg_ff[0] <= csr_data;
            REG_ORIGIN_Y: cfg_ff[1] <= csr_data;
            REG_ORIGIN_Z: cfg_ff[2] <= csr_data;
            REG_TARGET_X: cfg_ff[3] <= csr_data;
            REG_TARGET_Y: cfg_ff[4] <= csr_data;
            REG_TARGET_Z: cfg_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   coord_type lo_c [3];
   coord_type hi_c [3];
   assign lo_c[0] = req_box.box_min_x;
   assign lo_c[1] = req_box.box_min_y;
   assign lo_c[2] = req_box.box_min_z;
   assign hi_c[0] = req_box.box_max_x;
   assign hi_c[1] = req_box.box_max_y;
   assign hi_c[2] = req_box.box_max_z;

   logic signed [DIFF_W-1:0] dir      [3];
   logic [DIFF_W-1:0]        dir_mag  [3];
   logic                     dir_neg  [3];

   logic signed [DIFF_W-1:0] d_lo     [3];
   logic signed [DIFF_W-1:0] d_hi     [3];
   logic [DIFF_W-1:0]        lo_mag_in [3];
   logic [DIFF_W-1:0]        hi_mag_in [3];
   logic                     lo_neg_in [3];
   logic                     hi_neg_in [3];
   axis_flag_type            flag_in   [3];

   logic [DIFF_W-1:0]        lo_mag_ff [3];
   logic [DIFF_W-1:0]        hi_mag_ff [3];
   logic                     lo_neg_ff [3];
   logic                     hi_neg_ff [3];
   axis_flag_type            flag_ff   [3];
   logic                     valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dir[k]     = DIFF_W'(cfg_ff[k+3]) - DIFF_W'(cfg_ff[k]);
         dir_neg[k] = dir[k][DIFF_W-1];
         dir_mag[k] = dir_neg[k] ? DIFF_W'(-dir[k]) : DIFF_W'(dir[k]);

         d_lo[k]      = DIFF_W'(lo_c[k]) - DIFF_W'(cfg_ff[k]);
         d_hi[k]      = DIFF_W'(hi_c[k]) - DIFF_W'(cfg_ff[k]);
         lo_neg_in[k] = d_lo[k][DIFF_W-1];
         hi_neg_in[k] = d_hi[k][DIFF_W-1];
         lo_mag_in[k] = lo_neg_in[k] ? DIFF_W'(-d_lo[k]) : DIFF_W'(d_lo[k]);
         hi_mag_in[k] = hi_neg_in[k] ? DIFF_W'(-d_hi[k]) : DIFF_W'(d_hi[k]);

         flag_in[k].zero_dir = (dir[k] == '0);
         // origin between the two planes, in either order
         flag_in[k].in_slab  = (lo_c[k] < hi_c[k])
            ? (lo_c[k] <= cfg_ff[k] && cfg_ff[k] <= hi_c[k])
            : (hi_c[k] <= cfg_ff[k] && cfg_ff[k] <= lo_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      for (int k = 0; k < 3; k++) begin
         lo_mag_ff[k] <= lo_mag_in[k];
         hi_mag_ff[k] <= hi_mag_in[k];
         lo_neg_ff[k] <= lo_neg_in[k];
         hi_neg_ff[k] <= hi_neg_in[k];
         flag_ff[k]   <= flag_in[k];
      end
   end

   t_type t_lo [3];
   t_type t_hi [3];

   for (genvar k = 0; k < 3; k++) begin : g_axis
      rbst_div_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_div_lo (
         .clock   (clock),
         .num_mag (lo_mag_ff[k]),
         .num_neg (lo_neg_ff[k]),
         .den_mag (dir_mag[k]),
         .den_neg (dir_neg[k]),
         .quot    (t_lo[k])
      );
      rbst_div_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_div_hi (
         .clock   (clock),
         .num_mag (hi_mag_ff[k]),
         .num_neg (hi_neg_ff[k]),
         .den_mag (dir_mag[k]),
         .den_neg (dir_neg[k]),
         .quot    (t_hi[k])
      );
   end

   // side information travels alongside the divider stages
   logic          side_valid_ff [LANE_LAT];
   axis_flag_type side_flag_ff  [LANE_LAT][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            side_valid_ff[s] <= 1'b0;
         end
      end else begin
         side_valid_ff[0] <= valid_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            side_valid_ff[s] <= side_valid_ff[s-1];
         end
      end
      for (int k = 0; k < 3; k++) begin
         side_flag_ff[0][k] <= flag_ff[k];
         for (int s = 1; s < LANE_LAT; s++) begin
            side_flag_ff[s][k] <= side_flag_ff[s-1][k];
         end
      end
   end

   rbst_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .valid     (side_valid_ff[LANE_LAT-1]),
      .t_lo      (t_lo),
      .t_hi      (t_hi),
      .flag      (side_flag_ff[LANE_LAT-1]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without a matching transfer");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT (rsp_valid || $past(reset, LAT - 1)))
      else $error("transfer produced no result");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit == (rsp_data.t_enter <= rsp_data.t_exit)))
      else $error("hit flag disagrees with entry and exit");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");
`endif

endmodule
